FILE: hdl/dlap_pkg.sv
package dlap_pkg;

  // Delay line geometry
  localparam int unsigned LINE_DEPTH = 32768;
  localparam int unsigned PTR_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  // Field widths
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned DELAY_W  = 15;
  localparam int unsigned PROD_W   = SAMPLE_W + GAIN_W;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(1);
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(16384);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY = 2'd0,
    REG_GAIN  = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_SUMV,
    ST_MUL2,
    ST_OUT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch sample, read line entry
    logic mul1;      // g * d
    logic sumv;      // v = x + g*d, write line, advance pointer
    logic mul2;      // g * v
    logic load_out;  // y into output register
  } dlap_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic dly_busy;  // delay reduction in flight
    logic out_free;  // output register can take a result
  } dlap_sts_t;

endpackage

FILE: hdl/dlap_ctrl.sv
module dlap_ctrl
  import dlap_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dlap_sts_t sts_i,
  output dlap_cmd_t cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = sts_i.dly_busy;
        if (in_valid_i && !sts_i.dly_busy) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_RD;
        end
      end
      ST_RD: begin
        cmd_o.mul1 = 1'b1;
        state_d    = ST_SUMV;
      end
      ST_SUMV: begin
        cmd_o.sumv = 1'b1;
        state_d    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = ST_OUT;
      end
      ST_OUT: begin
        // hand off the result and take the next sample in the same cycle
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          in_stall_o     = sts_i.dly_busy;
          if (in_valid_i && !sts_i.dly_busy) begin
            cmd_o.capture = 1'b1;
            state_d       = ST_RD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_accept_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> (state_q == ST_IDLE || state_q == ST_OUT))
    else $error("sample accepted mid computation");

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.dly_busy |-> in_stall_o)
    else $error("sample accepted while delay is settling");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> sts_i.out_free)
    else $error("output register overwritten");
`endif

endmodule

FILE: hdl/dlap_datapath.sv
module dlap_datapath
  import dlap_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i,
  input  logic signed [SAMPLE_W-1:0]  sample_in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [SAMPLE_W-1:0]  sample_out_o,
  input  dlap_cmd_t                   cmd_i,
  output dlap_sts_t                   sts_o
);

  // Round Q1.15 product back to Q1.23, half toward +inf
  function automatic logic signed [SAMPLE_W:0] rnd15(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + PROD_W'(16384);
    return t[PROD_W-1:15];
  endfunction

  // Saturate to 24-bit sample range
  function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [SAMPLE_W+1:0] s);
    logic signed [SAMPLE_W+1:0] hi;
    logic signed [SAMPLE_W+1:0] lo;
    hi = (SAMPLE_W+2)'(8388607);
    lo = -(SAMPLE_W+2)'(8388608);
    if (s > hi) begin
      return {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (s < lo) begin
      return {1'b1, {(SAMPLE_W-1){1'b0}}};
    end
    return s[SAMPLE_W-1:0];
  endfunction

  logic                       cfg_wr;
  logic signed [GAIN_W-1:0]   gain_q;
  logic [PTR_W-1:0]           dl_q;
  logic                       dly_busy;

  logic [PTR_W-1:0]           wp_q;
  logic                       full_q;
  logic [PTR_W:0]             diff;
  logic [PTR_W-1:0]           rp;

  logic [SAMPLE_W-1:0]        mem [LINE_DEPTH];
  logic [SAMPLE_W-1:0]        mem_rd_q;
  logic                       rd_valid_q;

  logic signed [SAMPLE_W-1:0] x_q;
  logic signed [SAMPLE_W-1:0] d;
  logic signed [SAMPLE_W-1:0] d_q;
  logic signed [PROD_W-1:0]   p1_q;
  logic signed [SAMPLE_W-1:0] v_q;
  logic signed [PROD_W-1:0]   p2_q;
  logic signed [SAMPLE_W+1:0] sum_v;
  logic signed [SAMPLE_W+1:0] sum_y;
  logic signed [SAMPLE_W-1:0] out_q;
  logic                       out_valid_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  // Gain register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
    end else if (cfg_wr && cfg_index_i == REG_GAIN) begin
      gain_q <= cfg_data_i;
    end
  end

  // Delay register, reduced modulo the line depth
  if (LINE_DEPTH < (1 << DELAY_W)) begin : g_mod
    localparam int unsigned RSH   = DELAY_W + PTR_W;
    localparam longint      RECIP = ((longint'(1) << RSH) + LINE_DEPTH - 1) / LINE_DEPTH;

    logic [DELAY_W-1:0]   raw_q;
    logic [2*DELAY_W:0]   prod_q;
    logic                 s1_q;
    logic                 s2_q;
    logic [DELAY_W-1:0]   quo;
    logic [DELAY_W-1:0]   rem;

    // quotient by reciprocal multiply, exact for 15-bit delays
    assign quo = DELAY_W'(prod_q >> RSH);
    assign rem = raw_q - DELAY_W'(quo * DELAY_W'(LINE_DEPTH));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        raw_q  <= DELAY_RESET;
        prod_q <= '0;
        s1_q   <= 1'b0;
        s2_q   <= 1'b0;
        dl_q   <= PTR_W'(1);
      end else begin
        s1_q <= 1'b0;
        s2_q <= s1_q;
        if (cfg_wr && cfg_index_i == REG_DELAY) begin
          raw_q <= cfg_data_i[DELAY_W-1:0];
          s1_q  <= 1'b1;
        end
        if (s1_q) begin
          prod_q <= (2*DELAY_W+1)'(raw_q) * (2*DELAY_W+1)'(RECIP);
        end
        if (s2_q) begin
          dl_q <= PTR_W'(rem);
        end
      end
    end

    assign dly_busy = s1_q || s2_q;
  end else begin : g_nomod
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dl_q <= PTR_W'(1);
      end else if (cfg_wr && cfg_index_i == REG_DELAY) begin
        dl_q <= PTR_W'(cfg_data_i[DELAY_W-1:0]);
      end
    end

    assign dly_busy = 1'b0;
  end

  // Read position behind the write pointer, wrapped
  assign diff = {1'b0, wp_q} - {1'b0, dl_q};
  assign rp   = diff[PTR_W] ? PTR_W'(diff + (PTR_W+1)'(LINE_DEPTH)) : diff[PTR_W-1:0];

  // Write pointer; full_q marks that every entry has been written once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      full_q <= 1'b0;
    end else if (cmd_i.sumv) begin
      if (wp_q == PTR_W'(LINE_DEPTH - 1)) begin
        wp_q   <= '0;
        full_q <= 1'b1;
      end else begin
        wp_q <= wp_q + 1'b1;
      end
    end
  end

  assign sum_v = (SAMPLE_W+2)'(x_q) + (SAMPLE_W+2)'(rnd15(p1_q));
  assign sum_y = (SAMPLE_W+2)'(d_q) - (SAMPLE_W+2)'(rnd15(p2_q));

  // Line memory, one write and one read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.sumv) begin
      mem[wp_q] <= sat24(sum_v);
    end
    if (cmd_i.capture) begin
      mem_rd_q <= mem[rp];
    end
  end

  // Entries not yet written since reset read as zero
  assign d = rd_valid_q ? signed'(mem_rd_q) : '0;

  // Arithmetic pipeline
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x_q        <= sample_in_i;
      rd_valid_q <= full_q || (rp < wp_q);
    end
    if (cmd_i.mul1) begin
      d_q  <= d;
      p1_q <= gain_q * d;
    end
    if (cmd_i.sumv) begin
      v_q <= sat24(sum_v);
    end
    if (cmd_i.mul2) begin
      p2_q <= gain_q * v_q;
    end
    if (cmd_i.load_out) begin
      out_q <= sat24(sum_y);
    end
  end

  // Output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_out_o   = out_q;
  assign sts_o.dly_busy = dly_busy;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

`ifndef NO_ASSERTIONS
  a_wp_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.sumv && wp_q != PTR_W'(LINE_DEPTH - 1)) |=> (wp_q == $past(wp_q) + 1'b1))
    else $error("write pointer did not advance");

  a_wp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.sumv |=> $stable(wp_q))
    else $error("write pointer moved without a line write");

  a_full_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |=> full_q)
    else $error("line fill flag dropped");
`endif

endmodule

FILE: hdl/delay_line_allpass_filter_top.sv
// Schroeder allpass stage on a circular delay line.
//
// Input channel: in_valid_i / in_stall_o with sample_in_i (signed Q1.23).
// A beat is taken on a rising edge with valid high and stall low.
// Output channel: out_valid_o / out_stall_i with sample_out_o (signed Q1.23),
// one result beat per input beat, in order.
// Config channel: cfg_valid_i / cfg_ready_o, cfg_index_i selects
// 0 = delay in samples (15 bits), 1 = gain (signed Q1.15); other indexes are
// ignored. Write it only while the block is idle.
//
// Each sample goes through line read, g*d multiply, v sum with line write,
// g*v multiply and y sum into the output register, each a registered step;
// one sample is in flight at a time. The line depth covers every 15-bit
// delay, so a delay write takes effect at once and never stalls the input.
// When the receiver stalls, the result waits in the output register; the
// next sample is still computed and waits at the final step until it frees.
// Reset clears the pointer, sets delay 1 and gain 0.5; line entries not yet
// written since reset read as zero, so no clearing pass is needed.
module delay_line_allpass_filter_top
  import dlap_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] sample_out_o
);

  dlap_cmd_t cmd;
  dlap_sts_t sts;

  dlap_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dlap_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule
